// ===== hdl/pma3d_pkg.sv =====
// Shared constants, types and divider interface structs for the 3D position moving average.
package pma3d_pkg;

  localparam int DATA_W     = 24;
  localparam int WINDOW     = 90;
  localparam int LOG_W      = ($clog2(WINDOW) > 0) ? $clog2(WINDOW) : 1;
  localparam int SUM_W      = DATA_W + LOG_W;
  localparam int ADDR_W     = LOG_W;
  localparam int HELD_W     = $clog2(WINDOW + 1);
  localparam int HELD_OUT_W = 7;
  localparam int QUOT_W     = DATA_W;
  localparam int RADIX_BITS = 2;
  localparam int DIV_STEPS  = QUOT_W / RADIX_BITS;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);
  localparam int NUM_AX     = 3;
  localparam int AX_W       = 2;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [HELD_W-1:0]        held_t;

  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  dividend;
    logic [HELD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== hdl/pma3d_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pma3d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [(($clog2(DEPTH) > 0) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic [(($clog2(DEPTH) > 0) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/pma3d_div.sv =====
// Shared iterative restoring divider, two quotient bits per cycle.
module pma3d_div import pma3d_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [HELD_W-1:0] rem_r;
  logic [HELD_W-1:0] rem_nxt;
  logic [HELD_W-1:0] den_r;
  logic [QUOT_W-1:0] num_r;
  logic [QUOT_W-1:0] num_nxt;

  always_comb begin : div_step
    logic [HELD_W:0] trial;
    trial   = '0;
    rem_nxt = rem_r;
    num_nxt = num_r;
    for (int i = 0; i < RADIX_BITS; i++) begin
      trial   = {rem_nxt, num_nxt[QUOT_W-1]};
      num_nxt = {num_nxt[QUOT_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt    = HELD_W'(trial - {1'b0, den_r});
        num_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[HELD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEP_W'(DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The quotient is known to fit in QUOT_W bits, so the upper dividend bits
  // are already below the divisor and seed the partial remainder.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= HELD_W'(req.dividend[SUM_W-1:QUOT_W]);
      num_r <= req.dividend[QUOT_W-1:0];
      den_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = num_r;

endmodule

// ===== hdl/position_moving_average_3d.sv =====
// Top level: ring buffer, running sums and sequencer of the 3D position moving average.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall   | in_pos_x, in_pos_y, in_pos_z
//   out     | output    | out_valid / out_stall | out_avg_x/y/z, out_samples_held
//
// Each transaction runs from acceptance through the sum update and ring write, the shared
// divider once per axis, and the load of the result into the output registers.
// The next transaction can be accepted in the cycle after the load.
// Reset is synchronous and clears the sums, the write slot and the fill count.
// The input is stalled while a transaction is in work; a stalled result only
// holds the block once the next result is ready to be loaded.
module position_moving_average_3d import pma3d_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_W-1:0]     in_pos_x,
  input  logic [DATA_W-1:0]     in_pos_y,
  input  logic [DATA_W-1:0]     in_pos_z,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_W-1:0]     out_avg_x,
  output logic [DATA_W-1:0]     out_avg_y,
  output logic [DATA_W-1:0]     out_avg_z,
  output logic [HELD_OUT_W-1:0] out_samples_held
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]              state_r;
  logic [2:0]              state_nxt;
  logic [AX_W-1:0]         ax_r;
  logic [ADDR_W-1:0]       slot_r;
  held_t                   fill_r;
  sum_t                    sum_r [NUM_AX];
  sum_t                    sum_nxt [NUM_AX];
  data_t                   smp_r [NUM_AX];
  data_t                   res_r [NUM_AX];
  logic                    out_valid_r;
  data_t                   out_avg_r [NUM_AX];
  held_t                   out_held_r;
  logic                    in_take;
  logic                    out_free;
  logic                    full;
  logic                    ram_we;
  logic [NUM_AX*DATA_W-1:0] ram_wdata;
  logic [NUM_AX*DATA_W-1:0] ram_rdata;
  sum_t                    sel_sum;
  logic                    sel_neg;
  logic [SUM_W-1:0]        sel_mag;
  data_t                   quot_signed;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign full     = (fill_r == HELD_W'(WINDOW));

  assign ram_we    = (state_r == S_SUM);
  assign ram_wdata = {smp_r[2], smp_r[1], smp_r[0]};

  pma3d_ram #(
    .WIDTH (NUM_AX * DATA_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (slot_r),
    .wr_data (ram_wdata),
    .rd_addr (slot_r),
    .rd_data (ram_rdata)
  );

  always_comb begin
    for (int a = 0; a < NUM_AX; a++) begin
      sum_nxt[a] = sum_r[a] + sum_t'(smp_r[a]);
      if (full) begin
        sum_nxt[a] = sum_nxt[a] - sum_t'($signed(ram_rdata[a*DATA_W +: DATA_W]));
      end
    end
  end

  assign sel_sum = sum_r[ax_r];
  assign sel_neg = sel_sum[SUM_W-1];
  assign sel_mag = sel_neg ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);

  assign div_req.start    = (state_r == S_PREP);
  assign div_req.dividend = sel_mag + SUM_W'(fill_r >> 1);
  assign div_req.divisor  = fill_r;

  pma3d_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign quot_signed = sel_neg ? data_t'(-div_rsp.quot) : data_t'(div_rsp.quot);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        state_nxt = S_PREP;
      end
      S_PREP: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = (ax_r == AX_W'(NUM_AX - 1)) ? S_OUT : S_PREP;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ax_r        <= '0;
      slot_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      for (int a = 0; a < NUM_AX; a++) begin
        sum_r[a] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == S_SUM) begin
        for (int a = 0; a < NUM_AX; a++) begin
          sum_r[a] <= sum_nxt[a];
        end
        if (!full) begin
          fill_r <= fill_r + HELD_W'(1);
        end
        slot_r <= (slot_r == ADDR_W'(WINDOW - 1)) ? '0 : slot_r + ADDR_W'(1);
        ax_r   <= '0;
      end
      if (state_r == S_WAIT && div_rsp.done) begin
        ax_r <= ax_r + AX_W'(1);
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      smp_r[0] <= data_t'(in_pos_x);
      smp_r[1] <= data_t'(in_pos_y);
      smp_r[2] <= data_t'(in_pos_z);
    end
    if (state_r == S_WAIT && div_rsp.done) begin
      res_r[ax_r] <= quot_signed;
    end
    if (state_r == S_OUT && out_free) begin
      for (int a = 0; a < NUM_AX; a++) begin
        out_avg_r[a] <= res_r[a];
      end
      out_held_r <= fill_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_avg_x        = out_avg_r[0];
  assign out_avg_y        = out_avg_r[1];
  assign out_avg_z        = out_avg_r[2];
  assign out_samples_held = HELD_OUT_W'(out_held_r);

  a_accept_starts_update: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == S_SUM))
    else $error("accepted transaction did not enter the sum update");

  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (fill_r != '0) && (fill_r <= HELD_W'(WINDOW)))
    else $error("fill count out of range while a result is held");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_WAIT))
    else $error("divider finished outside the wait state");

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= ADDR_W'(WINDOW - 1))
    else $error("ring write slot beyond window");

endmodule
